// ----- hdl/wheel_mark_speed_regulator_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the wheel mark speed regulator
// Immediate-consequence and next-cycle checks on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef WHEEL_MARK_SPEED_REGULATOR_CORE_ASSERT_SVH
`define WHEEL_MARK_SPEED_REGULATOR_CORE_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define WMSR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define WMSR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/wmsr_pkg.sv -----
// ----------------------------------------------------------------------------
// Wheel mark speed regulator package
// Widths, duty constants, register indexes and lookup functions.
// ----------------------------------------------------------------------------
package wmsr_pkg;

    localparam int DUTY_W   = 15;
    localparam int COUNT_W  = 16;
    localparam int THRESH_W = 12;
    localparam int TARGET_W = 8;
    localparam int DEAD_W   = 3;
    localparam int TURN_W   = 3;
    localparam int MODE_W   = 2;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    // Wide enough for a duty plus the largest upward step (60 + 20 * 65535).
    localparam int STEP_W   = 22;

    typedef logic [DUTY_W-1:0]  duty_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [STEP_W-1:0]  step_t;

    localparam duty_t DUTY_MAX      = duty_t'(24000);
    localparam duty_t DUTY_STOP     = duty_t'(8400);
    localparam duty_t DUTY_STRAIGHT = duty_t'(9000);

    localparam count_t COUNT_SAT = '1;
    localparam logic [DEAD_W-1:0] DEAD_SAT = '1;

    localparam step_t STEP_SMALL  = step_t'(60);
    localparam step_t STEP_MEDIUM = step_t'(180);
    localparam step_t STEP_LARGE  = step_t'(240);
    localparam step_t STEP_BASE   = step_t'(60);

    // Item opcodes
    localparam logic OP_SAMPLE  = 1'b0;
    localparam logic OP_COMMAND = 1'b1;

    // Speed modes
    localparam logic [MODE_W-1:0] MODE_STOP   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SLOW   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_NORMAL = 2'd2;
    localparam logic [MODE_W-1:0] MODE_TURBO  = 2'd3;

    // Turn codes
    localparam logic [TURN_W-1:0] TURN_HARD_LEFT    = 3'd0;
    localparam logic [TURN_W-1:0] TURN_SLIGHT_LEFT  = 3'd1;
    localparam logic [TURN_W-1:0] TURN_STRAIGHT     = 3'd2;
    localparam logic [TURN_W-1:0] TURN_SLIGHT_RIGHT = 3'd3;
    localparam logic [TURN_W-1:0] TURN_HARD_RIGHT   = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_THRESHOLD   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS      = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_TARGET       = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_TARGET     = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TURBO_TARGET      = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_DUTY_START   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_DUTY_START = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TURBO_DUTY_START  = 4'd7;

    // Reset values of the configuration registers
    localparam logic [THRESH_W-1:0] LIGHT_THRESHOLD_RST = 12'd1900;
    localparam count_t              WINDOW_TICKS_RST    = 16'd1000;
    localparam logic [TARGET_W-1:0] SLOW_TARGET_RST     = 8'd2;
    localparam logic [TARGET_W-1:0] NORMAL_TARGET_RST   = 8'd3;
    localparam logic [TARGET_W-1:0] TURBO_TARGET_RST    = 8'd4;
    localparam duty_t SLOW_DUTY_RST   = duty_t'(7320);
    localparam duty_t NORMAL_DUTY_RST = duty_t'(7200);
    localparam duty_t TURBO_DUTY_RST  = duty_t'(7080);

    // Lowest drive duty each moving mode accepts.
    localparam duty_t SLOW_FLOOR   = duty_t'(7320);
    localparam duty_t NORMAL_FLOOR = duty_t'(7200);
    localparam duty_t TURBO_FLOOR  = duty_t'(7080);

    function automatic duty_t servo_duty_of(input logic [TURN_W-1:0] turn);
        duty_t d;
        unique case (turn)
            TURN_HARD_LEFT:    d = duty_t'(10800);
            TURN_SLIGHT_LEFT:  d = duty_t'(9600);
            TURN_STRAIGHT:     d = DUTY_STRAIGHT;
            TURN_SLIGHT_RIGHT: d = duty_t'(7800);
            TURN_HARD_RIGHT:   d = duty_t'(6840);
            default:           d = DUTY_STRAIGHT;
        endcase
        return d;
    endfunction

    function automatic duty_t clamp_duty(input duty_t v);
        return (v > DUTY_MAX) ? DUTY_MAX : v;
    endfunction

endpackage

// ----- hdl/wmsr_item_if.sv -----
// ----------------------------------------------------------------------------
// Input item channel
// Sample or command beat: opcode, sensor reading, turn code and speed mode.
// ----------------------------------------------------------------------------
interface wmsr_item_if
    import wmsr_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
);
    logic                    valid;
    logic                    ready;
    logic                    op;
    logic [SAMPLE_BITS-1:0]  sample;
    logic [TURN_W-1:0]       turn_code;
    logic [MODE_W-1:0]       speed_mode;

    modport source (output valid, op, sample, turn_code, speed_mode, input ready);
    modport sink   (input valid, op, sample, turn_code, speed_mode, output ready);
endinterface

// ----- hdl/wmsr_result_if.sv -----
// ----------------------------------------------------------------------------
// Result channel
// One beat per input item: servo and drive duty, fault flag and mark count.
// ----------------------------------------------------------------------------
interface wmsr_result_if
    import wmsr_pkg::*;
;
    logic         valid;
    logic         ready;
    duty_t        servo_duty;
    duty_t        drive_duty;
    logic         speed_fault;
    count_t       marks_seen;

    modport source (output valid, servo_duty, drive_duty, speed_fault, marks_seen,
                    input ready);
    modport sink   (input valid, servo_duty, drive_duty, speed_fault, marks_seen,
                    output ready);
endinterface

// ----- hdl/wmsr_cfg_if.sv -----
// ----------------------------------------------------------------------------
// Configuration write channel
// One beat writes one register, selected by index.
// ----------------------------------------------------------------------------
interface wmsr_cfg_if
    import wmsr_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/wheel_mark_speed_regulator_core.sv -----
// ----------------------------------------------------------------------------
// Wheel mark speed regulator core
// Counts wheel marks from light samples and regulates the drive duty per mode.
// ----------------------------------------------------------------------------
//  Channel   Direction  Beat contents
//  item      in         op, sample, turn_code, speed_mode
//  result    out        servo_duty, drive_duty, speed_fault, marks_seen
//  cfg       in         index, data (register write)
//
//  The state and the result register both load at the accept edge; the next
//  item can be taken in the following cycle unless a result waits and stalls.
//  The result register is the only buffer; item.ready drops only while a
//  result waits and result.ready is low. cfg is always ready.
//  Reset restores all registers and state to their reset values at once.
// ----------------------------------------------------------------------------
`include "wheel_mark_speed_regulator_core_assert.svh"

module wheel_mark_speed_regulator_core
    import wmsr_pkg::*;
#(
    parameter int DEAD_LIMIT  = 4,
    parameter int SAMPLE_BITS = 12
)(
    input  logic          clk,
    input  logic          rst_n,
    wmsr_item_if.sink     item,
    wmsr_result_if.source result,
    wmsr_cfg_if.sink      cfg
);

    localparam int CMP_W = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;
    localparam logic [DEAD_W-1:0] DEAD_LIM = DEAD_W'(DEAD_LIMIT);

    // Configuration registers
    logic [THRESH_W-1:0] light_threshold_reg;
    count_t              window_ticks_reg;
    logic [TARGET_W-1:0] slow_target_reg, normal_target_reg, turbo_target_reg;

    // Regulator state
    logic                on_mark_reg, on_mark_next;
    count_t              mark_count_reg, mark_count_next;
    count_t              tick_count_reg, tick_count_next;
    logic [DEAD_W-1:0]   dead_windows_reg, dead_windows_next;
    duty_t               slow_duty_reg, normal_duty_reg, turbo_duty_reg;
    duty_t               mode_duty_next;
    logic                mode_duty_we;
    duty_t               servo_hold_reg, servo_hold_next;
    duty_t               drive_hold_reg, drive_hold_next;

    // Result register
    logic                result_valid_reg;
    count_t              marks_seen_reg;
    logic                speed_fault_reg, speed_fault_next;

    logic                item_fire, cfg_fire;
    logic [CMP_W-1:0]    smp_ext, thr_ext;
    duty_t               cur_duty, duty_floor, new_duty, cmd_duty;
    logic [TARGET_W-1:0] goal;
    logic                window_done, adjust, duty_ok;
    count_t              shortfall, excess;
    step_t               step_down, step_up, up_sum;
    logic [DEAD_W-1:0]   dead_upd;
    duty_t               cfg_duty;

    assign item_fire = item.valid && item.ready;
    assign cfg_fire  = cfg.valid && cfg.ready;
    assign item.ready = !result_valid_reg || result.ready;
    assign cfg.ready  = 1'b1;

    assign result.valid       = result_valid_reg;
    assign result.servo_duty  = servo_hold_reg;
    assign result.drive_duty  = drive_hold_reg;
    assign result.speed_fault = speed_fault_reg;
    assign result.marks_seen  = marks_seen_reg;

    assign smp_ext  = CMP_W'(item.sample);
    assign thr_ext  = CMP_W'(light_threshold_reg);
    assign cfg_duty = clamp_duty(duty_t'(cfg.data));

    // Per-mode selection of the stored duty, target and floor.
    always_comb
    begin
        unique case (item.speed_mode)
            MODE_STOP:
            begin
                cur_duty   = DUTY_STOP;
                goal       = '0;
                duty_floor = DUTY_STOP;
            end
            MODE_SLOW:
            begin
                cur_duty   = slow_duty_reg;
                goal       = slow_target_reg;
                duty_floor = SLOW_FLOOR;
            end
            MODE_NORMAL:
            begin
                cur_duty   = normal_duty_reg;
                goal       = normal_target_reg;
                duty_floor = NORMAL_FLOOR;
            end
            MODE_TURBO:
            begin
                cur_duty   = turbo_duty_reg;
                goal       = turbo_target_reg;
                duty_floor = TURBO_FLOOR;
            end
        endcase
    end

    assign window_done = tick_count_reg > window_ticks_reg;
    assign dead_upd    = (mark_count_reg == '0)
                       ? ((dead_windows_reg == DEAD_SAT) ? DEAD_SAT : dead_windows_reg + 1'b1)
                       : '0;

    assign shortfall = COUNT_W'(goal) - mark_count_reg;
    assign excess    = mark_count_reg - COUNT_W'(goal);

    always_comb
    begin
        priority if (shortfall < COUNT_W'(3))
            step_down = STEP_SMALL;
        else if (shortfall < COUNT_W'(5))
            step_down = STEP_MEDIUM;
        else
            step_down = STEP_LARGE;

        // 20 * excess as (16 + 4) * excess.
        priority if (excess < COUNT_W'(3))
            step_up = STEP_SMALL;
        else if (excess < COUNT_W'(5))
            step_up = STEP_MEDIUM;
        else
            step_up = STEP_BASE + (step_t'(excess) << 4) + (step_t'(excess) << 2);
    end

    assign up_sum = step_t'(cur_duty) + step_up;

    always_comb
    begin
        priority if (COUNT_W'(goal) > mark_count_reg)
            new_duty = (step_t'(cur_duty) > step_down)
                     ? duty_t'(step_t'(cur_duty) - step_down) : '0;
        else if (COUNT_W'(goal) < mark_count_reg)
            new_duty = (up_sum > step_t'(DUTY_MAX)) ? DUTY_MAX : duty_t'(up_sum);
        else
            new_duty = cur_duty;
    end

    always_comb
    begin
        on_mark_next      = on_mark_reg;
        mark_count_next   = mark_count_reg;
        tick_count_next   = tick_count_reg;
        dead_windows_next = dead_windows_reg;
        servo_hold_next   = servo_hold_reg;
        drive_hold_next   = drive_hold_reg;
        speed_fault_next  = 1'b0;
        mode_duty_we      = 1'b0;
        mode_duty_next    = new_duty;
        adjust            = 1'b0;
        cmd_duty          = cur_duty;
        duty_ok           = 1'b1;

        if (item.op == OP_SAMPLE)
        begin
            // Only a rising crossing counts; a reading equal to the threshold is neutral.
            if (smp_ext > thr_ext && !on_mark_reg)
            begin
                on_mark_next = 1'b1;
                if (mark_count_reg != COUNT_SAT)
                    mark_count_next = mark_count_reg + 1'b1;
            end
            else if (smp_ext < thr_ext && on_mark_reg)
            begin
                on_mark_next = 1'b0;
            end
            if (tick_count_reg != COUNT_SAT)
                tick_count_next = tick_count_reg + 1'b1;
        end
        else
        begin
            if (item.turn_code <= TURN_HARD_RIGHT)
                servo_hold_next = servo_duty_of(item.turn_code);

            if (window_done)
            begin
                tick_count_next   = '0;
                mark_count_next   = '0;
                dead_windows_next = dead_upd;
                adjust = (dead_upd < DEAD_LIM) && (item.speed_mode != MODE_STOP);
            end

            if (adjust)
            begin
                cmd_duty     = new_duty;
                mode_duty_we = 1'b1;
            end

            duty_ok = (item.speed_mode == MODE_STOP) ? (cmd_duty == DUTY_STOP)
                                                     : (cmd_duty >= duty_floor);
            if (duty_ok && dead_windows_next < DEAD_LIM)
            begin
                drive_hold_next = cmd_duty;
            end
            else
            begin
                drive_hold_next  = DUTY_STOP;
                speed_fault_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_threshold_reg <= LIGHT_THRESHOLD_RST;
            window_ticks_reg    <= WINDOW_TICKS_RST;
            slow_target_reg     <= SLOW_TARGET_RST;
            normal_target_reg   <= NORMAL_TARGET_RST;
            turbo_target_reg    <= TURBO_TARGET_RST;
            slow_duty_reg       <= SLOW_DUTY_RST;
            normal_duty_reg     <= NORMAL_DUTY_RST;
            turbo_duty_reg      <= TURBO_DUTY_RST;
            on_mark_reg         <= 1'b0;
            mark_count_reg      <= '0;
            tick_count_reg      <= '0;
            dead_windows_reg    <= '0;
            servo_hold_reg      <= DUTY_STRAIGHT;
            drive_hold_reg      <= DUTY_STOP;
            result_valid_reg    <= 1'b0;
            speed_fault_reg     <= 1'b0;
            marks_seen_reg      <= '0;
        end
        else
        begin
            if (item_fire)
            begin
                on_mark_reg      <= on_mark_next;
                mark_count_reg   <= mark_count_next;
                tick_count_reg   <= tick_count_next;
                dead_windows_reg <= dead_windows_next;
                servo_hold_reg   <= servo_hold_next;
                drive_hold_reg   <= drive_hold_next;
                speed_fault_reg  <= speed_fault_next;
                // Marks shown on the result are those counted before any window clearing.
                marks_seen_reg   <= (item.op == OP_SAMPLE) ? mark_count_next : mark_count_reg;
                if (mode_duty_we)
                begin
                    unique case (item.speed_mode)
                        MODE_SLOW:   slow_duty_reg   <= mode_duty_next;
                        MODE_NORMAL: normal_duty_reg <= mode_duty_next;
                        MODE_TURBO:  turbo_duty_reg  <= mode_duty_next;
                        default:     ;
                    endcase
                end
            end

            if (item_fire)
                result_valid_reg <= 1'b1;
            else if (result.ready)
                result_valid_reg <= 1'b0;

            if (cfg_fire)
            begin
                unique case (cfg.index)
                    REG_LIGHT_THRESHOLD:   light_threshold_reg <= THRESH_W'(cfg.data);
                    REG_WINDOW_TICKS:      window_ticks_reg    <= COUNT_W'(cfg.data);
                    REG_SLOW_TARGET:       slow_target_reg     <= TARGET_W'(cfg.data);
                    REG_NORMAL_TARGET:     normal_target_reg   <= TARGET_W'(cfg.data);
                    REG_TURBO_TARGET:      turbo_target_reg    <= TARGET_W'(cfg.data);
                    REG_SLOW_DUTY_START:   slow_duty_reg       <= cfg_duty;
                    REG_NORMAL_DUTY_START: normal_duty_reg     <= cfg_duty;
                    REG_TURBO_DUTY_START:  turbo_duty_reg      <= cfg_duty;
                    default:               ;
                endcase
            end
        end
    end

    `WMSR_ASSERT_SAME(a_fault_forces_stop,
        result_valid_reg && speed_fault_reg, drive_hold_reg == DUTY_STOP,
        "fault result without stop duty")
    `WMSR_ASSERT_NEXT(a_sample_never_faults,
        item_fire && item.op == OP_SAMPLE, result_valid_reg && !speed_fault_reg,
        "sample beat produced a fault or no result")
    `WMSR_ASSERT_NEXT(a_window_clears_marks,
        item_fire && item.op == OP_COMMAND && window_done,
        mark_count_reg == '0 && tick_count_reg == '0,
        "window end did not clear the counters")
    `WMSR_ASSERT_SAME(a_duties_in_range,
        1'b1,
        slow_duty_reg <= DUTY_MAX && normal_duty_reg <= DUTY_MAX
            && turbo_duty_reg <= DUTY_MAX,
        "mode duty above the duty ceiling")
    `WMSR_ASSERT_SAME(a_dead_wheel_faults,
        result_valid_reg && dead_windows_reg >= DEAD_LIM
            && $past(item_fire) && $past(item.op) == OP_COMMAND,
        speed_fault_reg,
        "dead wheel command without fault")

endmodule

// ----- sim/wheel_mark_speed_regulator_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wheel mark speed regulator core testbench
// Drives sample and command beats through the item channel with bursty
// timing and a stalling result receiver. It keeps its own model of the
// mark counter, the tick window, the per-mode duty feedback and the fault
// logic, and compares every result beat field by field. Configuration is
// rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module wheel_mark_speed_regulator_core_test;
    import wmsr_pkg::*;

    localparam int DEAD_WINDOW_LIMIT = 4;
    localparam int SENSOR_BITS       = 12;

    typedef struct packed {
        duty_t  servo_duty;
        duty_t  drive_duty;
        logic   speed_fault;
        count_t marks_seen;
    } regulator_beat_t;

    logic clk;
    logic rst_n;

    wmsr_item_if #(.SAMPLE_BITS(SENSOR_BITS)) item_bus ();
    wmsr_result_if                          result_bus ();
    wmsr_cfg_if                             cfg_bus ();

    wheel_mark_speed_regulator_core #(
        .DEAD_LIMIT  (DEAD_WINDOW_LIMIT),
        .SAMPLE_BITS (SENSOR_BITS)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    // Predicted configuration.
    logic [THRESH_W-1:0] cfg_threshold;
    count_t              cfg_window;
    logic [TARGET_W-1:0] cfg_target [3];
    duty_t               cfg_duty_start [3];

    // Predicted regulator state.
    logic              wheel_on_mark;
    count_t            marks_in_window;
    count_t            ticks_in_window;
    logic [DEAD_W-1:0] empty_windows;
    duty_t             mode_duty_held [3];
    duty_t             servo_now;
    duty_t             drive_now;

    regulator_beat_t results_due [$];
    regulator_beat_t head_beat;
    int              mismatch_count = 0;
    int              items_sent = 0;

    // Sender burst shaping.
    int burst_left  = 0;
    int burst_limit = 40;
    int gap_limit   = 6;

    // Receiver stall pattern.
    logic [15:0] stall_mask = '1;
    int          stall_left = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(100_000_000);
        $display("Regression FAIL");
        $finish;
    end

    // The receiver walks a 16-bit ready pattern and picks a new one whenever
    // stall_left runs out; about a quarter of the patterns never stall.
    initial
    begin
        result_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left == 0)
            begin
                stall_mask = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
                stall_left = 64;
            end
            result_bus.ready <= stall_mask[stall_left % 16];
            stall_left--;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= 20)
            $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    endtask

    // Outputs are sampled at the falling edge; a beat seen there with valid
    // and ready high is taken at the next rising edge.
    always @(negedge clk)
    begin
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (results_due.size() == 0)
            begin
                report_mismatch("result beat with nothing pending", 32'd0,
                                32'(result_bus.marks_seen));
            end
            else
            begin
                head_beat = results_due.pop_front();
                if (result_bus.servo_duty !== head_beat.servo_duty)
                    report_mismatch("servo_duty", 32'(head_beat.servo_duty),
                                    32'(result_bus.servo_duty));
                if (result_bus.drive_duty !== head_beat.drive_duty)
                    report_mismatch("drive_duty", 32'(head_beat.drive_duty),
                                    32'(result_bus.drive_duty));
                if (result_bus.speed_fault !== head_beat.speed_fault)
                    report_mismatch("speed_fault", 32'(head_beat.speed_fault),
                                    32'(result_bus.speed_fault));
                if (result_bus.marks_seen !== head_beat.marks_seen)
                    report_mismatch("marks_seen", 32'(head_beat.marks_seen),
                                    32'(result_bus.marks_seen));
            end
        end
    end

    function automatic void reset_predictor();
        cfg_threshold     = LIGHT_THRESHOLD_RST;
        cfg_window        = WINDOW_TICKS_RST;
        cfg_target[0]     = SLOW_TARGET_RST;
        cfg_target[1]     = NORMAL_TARGET_RST;
        cfg_target[2]     = TURBO_TARGET_RST;
        cfg_duty_start[0] = SLOW_DUTY_RST;
        cfg_duty_start[1] = NORMAL_DUTY_RST;
        cfg_duty_start[2] = TURBO_DUTY_RST;
        wheel_on_mark     = 1'b0;
        marks_in_window   = '0;
        ticks_in_window   = '0;
        empty_windows     = '0;
        for (int k = 0; k < 3; k++)
            mode_duty_held[k] = cfg_duty_start[k];
        servo_now = DUTY_STRAIGHT;
        drive_now = DUTY_STOP;
    endfunction

    function automatic duty_t servo_for_turn(input logic [TURN_W-1:0] turn);
        case (turn)
            TURN_HARD_LEFT:    return duty_t'(10800);
            TURN_SLIGHT_LEFT:  return duty_t'(9600);
            TURN_STRAIGHT:     return DUTY_STRAIGHT;
            TURN_SLIGHT_RIGHT: return duty_t'(7800);
            default:           return duty_t'(6840);
        endcase
    endfunction

    // Advances the predicted state by one item and returns its result beat.
    function automatic regulator_beat_t regulate_step(input logic op,
                                                      input logic [SENSOR_BITS-1:0] level,
                                                      input logic [TURN_W-1:0] turn,
                                                      input logic [MODE_W-1:0] mode);
        regulator_beat_t beat;
        int   duty;
        int   goal;
        int   marks;
        int   diff;
        int   step;
        logic duty_ok;

        beat.speed_fault = 1'b0;
        beat.marks_seen  = marks_in_window;
        if (op == OP_SAMPLE)
        begin
            if (level > cfg_threshold && !wheel_on_mark)
            begin
                if (marks_in_window != COUNT_SAT)
                    marks_in_window++;
                wheel_on_mark = 1'b1;
            end
            else if (level < cfg_threshold && wheel_on_mark)
            begin
                wheel_on_mark = 1'b0;
            end
            if (ticks_in_window != COUNT_SAT)
                ticks_in_window++;
            beat.marks_seen = marks_in_window;
        end
        else
        begin
            if (turn <= TURN_HARD_RIGHT)
                servo_now = servo_for_turn(turn);
            goal = 0;
            if (mode == MODE_STOP)
            begin
                duty = int'(DUTY_STOP);
            end
            else
            begin
                duty = int'(mode_duty_held[mode - 1]);
                goal = int'(cfg_target[mode - 1]);
            end

            if (ticks_in_window > cfg_window)
            begin
                ticks_in_window = '0;
                marks = int'(marks_in_window);
                if (marks == 0)
                begin
                    if (empty_windows != DEAD_SAT)
                        empty_windows++;
                end
                else
                begin
                    empty_windows = '0;
                end
                if (int'(empty_windows) < DEAD_WINDOW_LIMIT && mode != MODE_STOP)
                begin
                    if (goal > marks)
                    begin
                        diff = goal - marks;
                        step = (diff < 3) ? int'(STEP_SMALL) :
                               (diff < 5) ? int'(STEP_MEDIUM) : int'(STEP_LARGE);
                        duty = (duty > step) ? duty - step : 0;
                    end
                    else if (goal < marks)
                    begin
                        diff = marks - goal;
                        step = (diff < 3) ? int'(STEP_SMALL) :
                               (diff < 5) ? int'(STEP_MEDIUM) : int'(STEP_BASE) + 20 * diff;
                        duty = duty + step;
                        if (duty > int'(DUTY_MAX))
                            duty = int'(DUTY_MAX);
                    end
                    mode_duty_held[mode - 1] = duty_t'(duty);
                end
                marks_in_window = '0;
            end

            case (mode)
                MODE_STOP:   duty_ok = (duty == int'(DUTY_STOP));
                MODE_SLOW:   duty_ok = (duty >= int'(SLOW_FLOOR));
                MODE_NORMAL: duty_ok = (duty >= int'(NORMAL_FLOOR));
                default:     duty_ok = (duty >= int'(TURBO_FLOOR));
            endcase
            if (duty_ok && int'(empty_windows) < DEAD_WINDOW_LIMIT)
            begin
                drive_now = duty_t'(duty);
            end
            else
            begin
                drive_now = DUTY_STOP;
                beat.speed_fault = 1'b1;
            end
        end
        beat.servo_duty = servo_now;
        beat.drive_duty = drive_now;
        return beat;
    endfunction

    // Sends one item. Inside a burst valid stays high from one beat to the
    // next; a burst ends with valid low and a gap before the next burst.
    task automatic send_item(input logic op, input logic [SENSOR_BITS-1:0] level,
                             input logic [TURN_W-1:0] turn, input logic [MODE_W-1:0] mode);
        logic took;

        if (burst_left == 0)
        begin
            repeat ($urandom_range(1, gap_limit)) @(posedge clk);
            burst_left = $urandom_range(1, burst_limit);
        end
        item_bus.valid      <= 1'b1;
        item_bus.op         <= op;
        item_bus.sample     <= level;
        item_bus.turn_code  <= turn;
        item_bus.speed_mode <= mode;
        do
        begin
            @(negedge clk);
            took = item_bus.ready;
            @(posedge clk);
        end
        while (!took);
        results_due.push_back(regulate_step(op, level, turn, mode));
        items_sent++;
        burst_left--;
        if (burst_left == 0)
            item_bus.valid <= 1'b0;
    endtask

    // Must be called in the time step of the last accepted beat.
    task automatic pause_sender();
        if (burst_left != 0)
        begin
            item_bus.valid <= 1'b0;
            burst_left = 0;
        end
    endtask

    task automatic wait_results_done();
        int guard;

        pause_sender();
        guard = 0;
        while (results_due.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        if (results_due.size() != 0)
        begin
            report_mismatch("result beats never returned", results_due.size(), 0);
            results_due.delete();
        end
    endtask

    task automatic send_sample(input logic [SENSOR_BITS-1:0] level);
        send_item(OP_SAMPLE, level, TURN_W'($urandom_range(0, 7)),
                  MODE_W'($urandom_range(0, 3)));
    endtask

    task automatic send_noise();
        send_item(1'($urandom_range(0, 1)), SENSOR_BITS'($urandom_range(0, 4095)),
                  TURN_W'($urandom_range(0, 7)), MODE_W'($urandom_range(0, 3)));
    endtask

    function automatic logic [SENSOR_BITS-1:0] bright_level();
        return SENSOR_BITS'($urandom_range(cfg_threshold + 1, 4095));
    endfunction

    function automatic logic [SENSOR_BITS-1:0] dark_level();
        if (cfg_threshold == 0)
            return '0;
        return SENSOR_BITS'($urandom_range(0, cfg_threshold - 1));
    endfunction

    // Only called while the block is idle.
    task automatic write_register(input logic [CFG_IDX_W-1:0] reg_index,
                                  input logic [CFG_DATA_W-1:0] value);
        logic took;
        int   k;

        @(posedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= reg_index;
        cfg_bus.data  <= value;
        do
        begin
            @(negedge clk);
            took = cfg_bus.ready;
            @(posedge clk);
        end
        while (!took);
        cfg_bus.valid <= 1'b0;

        case (reg_index)
            REG_LIGHT_THRESHOLD:
                cfg_threshold = value[THRESH_W-1:0];
            REG_WINDOW_TICKS:
                cfg_window = value;
            REG_SLOW_TARGET, REG_NORMAL_TARGET, REG_TURBO_TARGET:
                cfg_target[reg_index - REG_SLOW_TARGET] = value[TARGET_W-1:0];
            REG_SLOW_DUTY_START, REG_NORMAL_DUTY_START, REG_TURBO_DUTY_START:
            begin
                k = int'(reg_index - REG_SLOW_DUTY_START);
                cfg_duty_start[k] = value[DUTY_W-1:0];
                mode_duty_held[k] = (value[DUTY_W-1:0] > DUTY_MAX) ? DUTY_MAX
                                                                   : value[DUTY_W-1:0];
            end
            default:
                ;
        endcase
    endtask

    task automatic load_settings(input logic [15:0] thresh, input logic [15:0] window,
                                 input logic [15:0] t_slow, input logic [15:0] t_normal,
                                 input logic [15:0] t_turbo, input logic [15:0] d_slow,
                                 input logic [15:0] d_normal, input logic [15:0] d_turbo);
        wait_results_done();
        write_register(REG_LIGHT_THRESHOLD, thresh);
        write_register(REG_WINDOW_TICKS, window);
        write_register(REG_SLOW_TARGET, t_slow);
        write_register(REG_NORMAL_TARGET, t_normal);
        write_register(REG_TURBO_TARGET, t_turbo);
        write_register(REG_SLOW_DUTY_START, d_slow);
        write_register(REG_NORMAL_DUTY_START, d_normal);
        write_register(REG_TURBO_DUTY_START, d_turbo);
    endtask

    // Produces the given number of rising crossings, pads with dark samples, or noise
    // items at noise_pct percent, until the tick window has run out, then closes it with a command.
    task automatic feed_window(input int marks, input logic [TURN_W-1:0] turn,
                               input logic [MODE_W-1:0] mode, input int noise_pct);
        for (int n = 0; n < marks; n++)
        begin
            if (wheel_on_mark)
                send_sample(dark_level());
            send_sample(bright_level());
        end
        while (ticks_in_window <= cfg_window)
        begin
            if ($urandom_range(1, 100) <= noise_pct)
                send_noise();
            else
                send_sample(dark_level());
        end
        send_item(OP_COMMAND, SENSOR_BITS'($urandom), turn, mode);
    endtask

    // Reset configuration: threshold edges, every turn code and every mode.
    task automatic test_directed_fields();
        send_sample(12'd0);
        send_sample(12'hFFF);
        send_sample(LIGHT_THRESHOLD_RST);
        send_sample(SENSOR_BITS'(LIGHT_THRESHOLD_RST - 1));
        send_sample(LIGHT_THRESHOLD_RST);
        send_sample(SENSOR_BITS'(LIGHT_THRESHOLD_RST + 1));
        for (int t = 0; t < 8; t++)
            send_item(OP_COMMAND, SENSOR_BITS'($urandom), TURN_W'(t), MODE_W'(t % 4));
        wait_results_done();
    endtask

    task automatic test_window_feedback();
        load_settings(16'd1500, 16'd3, 16'd6, 16'd6, 16'd6, 16'd9000, 16'd9000, 16'd9000);
        // Each shortfall class of the duty step, an exact hit, then each excess class.
        feed_window(5, TURN_STRAIGHT, MODE_SLOW, 0);
        feed_window(3, TURN_HARD_LEFT, MODE_SLOW, 0);
        feed_window(1, TURN_SLIGHT_LEFT, MODE_SLOW, 0);
        feed_window(6, TURN_SLIGHT_RIGHT, MODE_SLOW, 0);
        feed_window(7, TURN_HARD_RIGHT, MODE_NORMAL, 0);
        feed_window(9, 3'd5, MODE_NORMAL, 0);
        feed_window(12, 3'd6, MODE_TURBO, 0);
        feed_window(20, 3'd7, MODE_TURBO, 0);
        feed_window(8, TURN_STRAIGHT, MODE_STOP, 0);

        // Slow duty walks below its floor and faults.
        wait_results_done();
        write_register(REG_SLOW_DUTY_START, 16'd7400);
        feed_window(5, TURN_STRAIGHT, MODE_SLOW, 0);
        feed_window(5, TURN_STRAIGHT, MODE_SLOW, 0);

        // A downward step larger than the duty bottoms out at zero.
        wait_results_done();
        write_register(REG_SLOW_DUTY_START, 16'd100);
        feed_window(1, TURN_STRAIGHT, MODE_SLOW, 0);

        // Dead wheel: empty windows past the limit and up to saturation.
        for (int w = 0; w < 9; w++)
            feed_window(0, TURN_W'(w % 8), MODE_W'(w % 4), 0);
        send_item(OP_COMMAND, 12'd0, TURN_STRAIGHT, MODE_STOP);
        feed_window(2, TURN_STRAIGHT, MODE_NORMAL, 0);

        // Start values above the duty range load as the maximum.
        wait_results_done();
        write_register(REG_NORMAL_DUTY_START, 16'h7FFF);
        write_register(REG_TURBO_DUTY_START, 16'd24001);
        feed_window(20, TURN_HARD_LEFT, MODE_NORMAL, 0);
        feed_window(20, TURN_HARD_RIGHT, MODE_TURBO, 0);
        wait_results_done();
    endtask

    task automatic test_register_extremes();
        // Top threshold: no reading can make a mark.
        load_settings(16'hFFFF, 16'd2, 16'(SLOW_TARGET_RST), 16'(NORMAL_TARGET_RST),
                      16'(TURBO_TARGET_RST), 16'(SLOW_DUTY_RST), 16'(NORMAL_DUTY_RST),
                      16'(TURBO_DUTY_RST));
        send_sample(12'hFFF);
        send_sample(12'hFFF);
        feed_window(0, TURN_STRAIGHT, MODE_SLOW, 0);

        // Zero threshold, upper data bits ignored.
        wait_results_done();
        write_register(REG_LIGHT_THRESHOLD, 16'hF000);
        send_sample(12'd0);
        send_sample(12'd1);
        send_sample(12'd0);
        send_sample(12'hFFF);
        send_item(OP_COMMAND, 12'd0, TURN_SLIGHT_LEFT, MODE_NORMAL);

        // Zero window: any tick ends it, a second command right after does not.
        wait_results_done();
        write_register(REG_LIGHT_THRESHOLD, 16'hF7D0);
        write_register(REG_WINDOW_TICKS, 16'd0);
        send_sample(12'd3000);
        send_item(OP_COMMAND, 12'd0, TURN_STRAIGHT, MODE_TURBO);
        send_item(OP_COMMAND, 12'd0, TURN_STRAIGHT, MODE_TURBO);
        wait_results_done();
        write_register(REG_WINDOW_TICKS, 16'd1);
        feed_window(1, TURN_HARD_LEFT, MODE_SLOW, 0);

        // Target extremes.
        wait_results_done();
        write_register(REG_SLOW_TARGET, 16'd0);
        write_register(REG_NORMAL_TARGET, 16'hFF80);
        write_register(REG_TURBO_TARGET, 16'd255);
        feed_window(1, TURN_STRAIGHT, MODE_SLOW, 0);
        feed_window(1, TURN_STRAIGHT, MODE_TURBO, 0);
        feed_window(3, TURN_STRAIGHT, MODE_NORMAL, 0);

        // Indexes past the register file change nothing.
        wait_results_done();
        for (int r = 8; r < 16; r++)
            write_register(CFG_IDX_W'(r), CFG_DATA_W'($urandom));
        feed_window(2, TURN_SLIGHT_RIGHT, MODE_SLOW, 0);
        wait_results_done();
    endtask

    // Collects many marks in a window that does not end, then shortens the
    // window so that one command closes it with a large excess.
    task automatic test_long_window();
        load_settings(16'd2048, 16'hFFFF, 16'(SLOW_TARGET_RST), 16'(NORMAL_TARGET_RST),
                      16'(TURBO_TARGET_RST), 16'(SLOW_DUTY_RST), 16'(NORMAL_DUTY_RST),
                      16'(TURBO_DUTY_RST));
        burst_limit = 400;
        gap_limit   = 1;
        for (int n = 0; n < 150; n++)
        begin
            send_sample(dark_level());
            send_sample(bright_level());
        end
        send_item(OP_COMMAND, 12'd0, TURN_STRAIGHT, MODE_SLOW);
        wait_results_done();
        write_register(REG_WINDOW_TICKS, 16'd100);
        send_item(OP_COMMAND, 12'd0, TURN_HARD_RIGHT, MODE_TURBO);
        send_sample(12'd0);
        wait_results_done();
        burst_limit = 40;
        gap_limit   = 6;
    endtask

    function automatic logic [15:0] pick_duty_start(input duty_t floor_duty);
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'(DUTY_MAX);
            2:       return 16'($urandom_range(24001, 32767));
            default: return 16'($urandom_range(floor_duty - 300, floor_duty + 600));
        endcase
    endfunction

    function automatic logic [15:0] pick_target();
        return ($urandom_range(0, 15) == 0) ? 16'd255 : 16'($urandom_range(0, 10));
    endfunction

    function automatic logic [15:0] pick_window();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'($urandom_range(21, 120));
            default: return 16'($urandom_range(1, 20));
        endcase
    endfunction

    // Phases of well-formed windows with random content and some noise.
    task automatic test_random_traffic();
        int stop_at;
        int phase;
        int windows;
        int dead_run;
        int goal;
        int marks;
        logic [MODE_W-1:0] mode;

        stop_at = items_sent + 1300;
        phase = 0;
        while (items_sent < stop_at)
        begin
            load_settings(16'($urandom_range(1, 4000)), pick_window(), pick_target(),
                          pick_target(), pick_target(), pick_duty_start(SLOW_FLOOR),
                          pick_duty_start(NORMAL_FLOOR), pick_duty_start(TURBO_FLOOR));
            if ($urandom_range(0, 3) == 0)
                write_register(CFG_IDX_W'($urandom_range(8, 15)), CFG_DATA_W'($urandom));
            windows  = $urandom_range(6, 16);
            dead_run = ($urandom_range(0, 2) == 0) ? $urandom_range(4, 9) : 0;
            for (int w = 0; w < windows && items_sent < stop_at; w++)
            begin
                mode = MODE_W'($urandom_range(0, 3));
                goal = (mode == MODE_STOP) ? 0 : int'(cfg_target[mode - 1]);
                case ($urandom_range(0, 4))
                    0:       marks = 0;
                    1:       marks = goal;
                    default: marks = $urandom_range(0, goal + 8);
                endcase
                if (w < dead_run)
                    marks = 0;
                feed_window(marks, TURN_W'($urandom_range(0, 7)), mode, 8);
                // Hold the sender until the block has answered everything.
                if (w == windows / 2 && (phase == 0 || $urandom_range(0, 2) == 0))
                    wait_results_done();
            end
            phase++;
        end
        wait_results_done();
    endtask

    initial
    begin
        item_bus.valid      <= 1'b0;
        item_bus.op         <= OP_SAMPLE;
        item_bus.sample     <= '0;
        item_bus.turn_code  <= TURN_STRAIGHT;
        item_bus.speed_mode <= MODE_STOP;
        cfg_bus.valid       <= 1'b0;
        cfg_bus.index       <= REG_LIGHT_THRESHOLD;
        cfg_bus.data        <= '0;
        rst_n               <= 1'b0;
        reset_predictor();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_fields();
        test_window_feedback();
        test_register_extremes();
        test_long_window();
        test_random_traffic();

        wait_results_done();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
